// File: src/krabe_pkg.sv
// shared types, constants and saturation helpers for the roll angle and bias estimator
package krabe_pkg;

    typedef enum logic [1:0] {
        SH_NONE,
        SH_GAIN,
        SH_DT
    } shift_t;

    typedef enum logic [1:0] {
        MUL_IDLE,
        MUL_RUN,
        MUL_FIN,
        MUL_DONE
    } mul_state_t;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_FIN
    } div_state_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_OUT
    } top_state_t;

    typedef enum logic [4:0] {
        STEP_DT,
        STEP_SQ_X,
        STEP_SQ_Y,
        STEP_SQ_Z,
        STEP_X0,
        STEP_T11,
        STEP_P00_BA,
        STEP_P00_AB,
        STEP_P00_T11,
        STEP_GAIN0,
        STEP_GAIN1,
        STEP_ANGLE,
        STEP_BIAS,
        STEP_COV_AA,
        STEP_COV_AB,
        STEP_COV_BA,
        STEP_COV_BB
    } step_t;

    typedef struct packed {
        logic               start;
        logic signed [48:0] op_a;
        logic signed [48:0] op_b;
        shift_t             shift;
    } mul_req_t;

    typedef struct packed {
        logic        start;
        logic [77:0] dividend;
        logic        neg;
        logic [47:0] den;
    } div_req_t;

    localparam logic [2:0] CFG_Q_ANGLE     = 3'd0;
    localparam logic [2:0] CFG_Q_BIAS      = 3'd1;
    localparam logic [2:0] CFG_R_TRUSTED   = 3'd2;
    localparam logic [2:0] CFG_R_UNTRUSTED = 3'd3;
    localparam logic [2:0] CFG_NSQ_LOW     = 3'd4;
    localparam logic [2:0] CFG_NSQ_HIGH    = 3'd5;

    localparam logic [46:0] Q_ANGLE_RST     = 47'd70368744;
    localparam logic [46:0] Q_BIAS_RST      = 47'd43980;
    localparam logic [46:0] R_TRUSTED_RST   = 47'd32985348833;
    localparam logic [46:0] R_UNTRUSTED_RST = 47'd879609302221;
    localparam logic [31:0] NSQ_LOW_RST     = 32'd54358179;
    localparam logic [31:0] NSQ_HIGH_RST    = 32'd81201746;

    // round(2^64 / 10^6): microseconds to Q32 seconds after a rounding shift by 32
    localparam logic [47:0] DT_RECIP = 48'd18446744073710;

    localparam logic [62:0] MUL_LIM  = 63'h4000_0000_0000_0000;
    localparam logic [30:0] GAIN_ONE = 31'h4000_0000;
    localparam logic [46:0] GAIN_LIM = 47'h7FFF_FFFF_FFFF;
    localparam logic [5:0]  DIV_LAST = 6'd47;

    localparam logic signed [65:0] S32_HI = 66'sd2147483647;
    localparam logic signed [65:0] S32_LO = -66'sd2147483648;
    localparam logic signed [65:0] S48_HI = 66'sd140737488355327;
    localparam logic signed [65:0] S48_LO = -66'sd140737488355328;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > S32_HI)
        begin
            return 32'sh7FFF_FFFF;
        end
        else if (v < S32_LO)
        begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [65:0] v);
        if (v > S48_HI)
        begin
            return 48'sh7FFF_FFFF_FFFF;
        end
        else if (v < S48_LO)
        begin
            return 48'sh8000_0000_0000;
        end
        return v[47:0];
    endfunction

endpackage

// File: src/krabe_mul.sv
// shared signed multiplier: two 48x24 partial products, rounding shift and clamp
module krabe_mul (
    input  logic                      clk,
    input  logic                      rst_n,
    input  krabe_pkg::mul_req_t       req,
    output logic                      done,
    output logic signed [63:0]        result
);

    krabe_pkg::mul_state_t state_reg, state_next;
    logic [47:0]       a_reg, a_next;
    logic [47:0]       b_reg, b_next;
    logic              neg_reg, neg_next;
    krabe_pkg::shift_t shift_reg, shift_next;
    logic              dsel_reg, dsel_next;
    logic [95:0]       acc_reg, acc_next;
    logic [63:0]       res_reg, res_next;

    logic [48:0] a_abs, b_abs;
    logic [23:0] digit;
    logic [71:0] pp;
    logic [95:0] acc_sum;
    logic [96:0] rc, rnd, shifted;
    logic [62:0] mag;
    logic [63:0] res_c;

    always_comb
    begin
        a_abs   = req.op_a[48] ? 49'(-req.op_a) : req.op_a;
        b_abs   = req.op_b[48] ? 49'(-req.op_b) : req.op_b;
        digit   = dsel_reg ? b_reg[47:24] : b_reg[23:0];
        pp      = a_reg * digit;
        acc_sum = {acc_reg[71:0], 24'b0} + {24'b0, pp};
        case (shift_reg)
            krabe_pkg::SH_GAIN: rc = 97'd1 << 29;
            krabe_pkg::SH_DT:   rc = 97'd1 << 31;
            default:            rc = '0;
        endcase
        rnd = {1'b0, acc_reg} + rc;
        case (shift_reg)
            krabe_pkg::SH_GAIN: shifted = rnd >> 30;
            krabe_pkg::SH_DT:   shifted = rnd >> 32;
            default:            shifted = rnd;
        endcase
        mag   = (shifted > {34'b0, krabe_pkg::MUL_LIM}) ? krabe_pkg::MUL_LIM : shifted[62:0];
        res_c = neg_reg ? 64'(-{1'b0, mag}) : {1'b0, mag};
    end

    always_comb
    begin
        state_next = state_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        neg_next   = neg_reg;
        shift_next = shift_reg;
        dsel_next  = dsel_reg;
        acc_next   = acc_reg;
        res_next   = res_reg;
        done       = 1'b0;
        case (state_reg)
            krabe_pkg::MUL_IDLE:
            begin
                if (req.start)
                begin
                    a_next     = a_abs[47:0];
                    b_next     = b_abs[47:0];
                    neg_next   = req.op_a[48] ^ req.op_b[48];
                    shift_next = req.shift;
                    dsel_next  = 1'b1;
                    acc_next   = '0;
                    state_next = krabe_pkg::MUL_RUN;
                end
            end
            krabe_pkg::MUL_RUN:
            begin
                acc_next  = acc_sum;
                dsel_next = 1'b0;
                if (!dsel_reg)
                begin
                    state_next = krabe_pkg::MUL_FIN;
                end
            end
            krabe_pkg::MUL_FIN:
            begin
                res_next   = res_c;
                state_next = krabe_pkg::MUL_DONE;
            end
            krabe_pkg::MUL_DONE:
            begin
                done       = 1'b1;
                state_next = krabe_pkg::MUL_IDLE;
            end
            default:
            begin
                state_next = krabe_pkg::MUL_IDLE;
            end
        endcase
    end

    assign result = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= krabe_pkg::MUL_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg     <= a_next;
        b_reg     <= b_next;
        neg_reg   <= neg_next;
        shift_reg <= shift_next;
        dsel_reg  <= dsel_next;
        acc_reg   <= acc_next;
        res_reg   <= res_next;
    end

endmodule

// File: src/krabe_div.sv
// restoring divider, one quotient bit per cycle, 48-bit saturating quotient
module krabe_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  krabe_pkg::div_req_t       req,
    output logic                      done,
    output logic signed [47:0]        quot
);

    krabe_pkg::div_state_t state_reg, state_next;
    logic [47:0] rem_reg, rem_next;
    logic [47:0] sh_reg, sh_next;
    logic [47:0] q_reg, q_next;
    logic [47:0] den_reg, den_next;
    logic        sat_reg, sat_next;
    logic        neg_reg, neg_next;
    logic [5:0]  cnt_reg, cnt_next;

    logic [48:0] trial, diff;
    logic        ge;
    logic [47:0] mag;

    always_comb
    begin
        trial = {rem_reg, sh_reg[47]};
        diff  = trial - {1'b0, den_reg};
        ge    = trial >= {1'b0, den_reg};
        mag   = (sat_reg || q_reg[47]) ? {1'b0, krabe_pkg::GAIN_LIM} : q_reg;
        quot  = neg_reg ? 48'(-mag) : mag;
    end

    always_comb
    begin
        state_next = state_reg;
        rem_next   = rem_reg;
        sh_next    = sh_reg;
        q_next     = q_reg;
        den_next   = den_reg;
        sat_next   = sat_reg;
        neg_next   = neg_reg;
        cnt_next   = cnt_reg;
        done       = 1'b0;
        case (state_reg)
            krabe_pkg::DIV_IDLE:
            begin
                if (req.start)
                begin
                    rem_next   = {18'b0, req.dividend[77:48]};
                    sat_next   = {18'b0, req.dividend[77:48]} >= req.den;
                    sh_next    = req.dividend[47:0];
                    q_next     = '0;
                    den_next   = req.den;
                    neg_next   = req.neg;
                    cnt_next   = '0;
                    state_next = krabe_pkg::DIV_RUN;
                end
            end
            krabe_pkg::DIV_RUN:
            begin
                rem_next = ge ? diff[47:0] : trial[47:0];
                q_next   = {q_reg[46:0], ge};
                sh_next  = {sh_reg[46:0], 1'b0};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == krabe_pkg::DIV_LAST)
                begin
                    state_next = krabe_pkg::DIV_FIN;
                end
            end
            krabe_pkg::DIV_FIN:
            begin
                done       = 1'b1;
                state_next = krabe_pkg::DIV_IDLE;
            end
            default:
            begin
                state_next = krabe_pkg::DIV_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= krabe_pkg::DIV_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
        q_reg   <= q_next;
        den_reg <= den_next;
        sat_reg <= sat_next;
        neg_reg <= neg_next;
        cnt_reg <= cnt_next;
    end

endmodule

// File: src/kalman_roll_angle_bias_estimator_top.sv
// top level: sequencer, filter state and registers of the roll angle and gyro bias estimator
//
// input word: operation, rate, angle_meas, dt_us, accel_x/y/z; taken when in_valid is high
// and in_stall is low. output word: angle_out, bias_out, gain_angle, accel_trusted; taken
// when out_valid is high and out_stall is low. one output word per input word.
// registers are written through cfg_we / cfg_index / cfg_data; the user must write them only
// while no word is in flight, as the block does not enforce it. an update word runs a fixed
// sequence on one shared multiplier (15 products including the time step scaling) and one
// bit-serial divider (2 divisions for the gains); out_valid rises after the last covariance
// product, and the next word can be taken once the output word is placed. when the innovation
// variance is not positive the two gain divisions are skipped.
// an initialize word skips the sequence and goes straight to the output register.
// in_stall stays high from accept until the output word is placed in the output register,
// so one word is in the sequencer at a time.
// a stalled output word holds; the next input word can be taken and worked on while it
// waits, and its result waits in turn until the output register frees.
// reset clears the angle and bias, loads the covariance with the process noise reset
// values, loads the register reset values and empties the output register.
module kalman_roll_angle_bias_estimator_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               operation,
    input  logic signed [25:0] rate,
    input  logic signed [24:0] angle_meas,
    input  logic [15:0]        dt_us,
    input  logic signed [16:0] accel_x,
    input  logic signed [16:0] accel_y,
    input  logic signed [16:0] accel_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] angle_out,
    output logic signed [31:0] bias_out,
    output logic [16:0]        gain_angle,
    output logic               accel_trusted,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [46:0]        cfg_data
);

    krabe_pkg::top_state_t state_reg, state_next;
    krabe_pkg::step_t      step_reg, step_next;

    logic [46:0] q_angle_reg, q_bias_reg, r_trusted_reg, r_untrusted_reg;
    logic [31:0] nsq_low_reg, nsq_high_reg;

    logic signed [31:0] angle_reg, angle_next;
    logic signed [31:0] bias_reg, bias_next;
    logic signed [47:0] caa_reg, caa_next;
    logic signed [47:0] cab_reg, cab_next;
    logic signed [47:0] cba_reg, cba_next;
    logic signed [47:0] cbb_reg, cbb_next;

    logic signed [25:0] rate_reg, rate_next;
    logic signed [24:0] y_reg, y_next;
    logic [15:0]        dtus_reg, dtus_next;
    logic signed [16:0] ax_reg, ax_next;
    logic signed [16:0] ay_reg, ay_next;
    logic signed [16:0] az_reg, az_next;

    logic [28:0]        dt_reg, dt_next;
    logic [33:0]        nsq_reg, nsq_next;
    logic               trusted_reg, trusted_next;
    logic signed [31:0] x0_reg, x0_next;
    logic signed [47:0] t11_reg, t11_next;
    logic signed [65:0] acc_reg, acc_next;
    logic signed [47:0] p00_reg, p00_next;
    logic signed [47:0] p01_reg, p01_next;
    logic signed [47:0] p10_reg, p10_next;
    logic signed [47:0] p11_reg, p11_next;
    logic signed [48:0] sden_reg, sden_next;
    logic [30:0]        g0_reg, g0_next;
    logic signed [47:0] g1_reg, g1_next;

    logic               out_valid_reg, out_valid_next;
    logic signed [31:0] angle_out_reg, angle_out_next;
    logic signed [31:0] bias_out_reg, bias_out_next;
    logic [16:0]        gain_out_reg, gain_out_next;
    logic               trusted_out_reg, trusted_out_next;

    krabe_pkg::mul_req_t mul_req;
    krabe_pkg::div_req_t div_req;
    logic                mul_done, div_done;
    logic signed [63:0]  mul_res;
    logic signed [47:0]  div_quot;

    logic signed [32:0] innov_c, ub_c;
    logic signed [48:0] sden_c;
    logic               sden_pos;
    logic [46:0]        r_sel;
    logic [47:0]        p00_abs, p10_abs;
    logic [65:0]        m66, x066, ang66, bias66, caa66, cab66, cba66, cbb66;
    logic [65:0]        t66, p00_66, p01_66, p10_66, p11_66, qa66, qb66;
    logic [33:0]        nsq_c;
    logic               is_div, unit_done;

    krabe_mul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (mul_req),
        .done   (mul_done),
        .result (mul_res)
    );

    krabe_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_comb
    begin
        innov_c  = {{8{y_reg[24]}}, y_reg} - {x0_reg[31], x0_reg};
        ub_c     = {{7{rate_reg[25]}}, rate_reg} - {bias_reg[31], bias_reg};
        r_sel    = trusted_reg ? r_trusted_reg : r_untrusted_reg;
        sden_c   = {p00_reg[47], p00_reg} + {2'b0, r_sel};
        sden_pos = !sden_c[48] && (sden_c != '0);
        p00_abs  = p00_reg[47] ? 48'(-p00_reg) : p00_reg;
        p10_abs  = p10_reg[47] ? 48'(-p10_reg) : p10_reg;
        m66      = {{2{mul_res[63]}}, mul_res};
        x066     = {{34{x0_reg[31]}}, x0_reg};
        ang66    = {{34{angle_reg[31]}}, angle_reg};
        bias66   = {{34{bias_reg[31]}}, bias_reg};
        caa66    = {{18{caa_reg[47]}}, caa_reg};
        cab66    = {{18{cab_reg[47]}}, cab_reg};
        cba66    = {{18{cba_reg[47]}}, cba_reg};
        cbb66    = {{18{cbb_reg[47]}}, cbb_reg};
        t66      = {{18{t11_reg[47]}}, t11_reg};
        p00_66   = {{18{p00_reg[47]}}, p00_reg};
        p01_66   = {{18{p01_reg[47]}}, p01_reg};
        p10_66   = {{18{p10_reg[47]}}, p10_reg};
        p11_66   = {{18{p11_reg[47]}}, p11_reg};
        qa66     = {19'b0, q_angle_reg};
        qb66     = {19'b0, q_bias_reg};
        nsq_c    = nsq_reg + mul_res[33:0];
        is_div   = (step_reg == krabe_pkg::STEP_GAIN0) || (step_reg == krabe_pkg::STEP_GAIN1);
        unit_done = is_div ? div_done : mul_done;
    end

    // operand selection for the shared units
    always_comb
    begin
        mul_req       = '0;
        mul_req.shift = krabe_pkg::SH_GAIN;
        case (step_reg)
            krabe_pkg::STEP_DT:
            begin
                mul_req.op_a  = {33'b0, dtus_reg};
                mul_req.op_b  = {1'b0, krabe_pkg::DT_RECIP};
                mul_req.shift = krabe_pkg::SH_DT;
            end
            krabe_pkg::STEP_SQ_X:
            begin
                mul_req.op_a  = {{32{ax_reg[16]}}, ax_reg};
                mul_req.op_b  = {{32{ax_reg[16]}}, ax_reg};
                mul_req.shift = krabe_pkg::SH_NONE;
            end
            krabe_pkg::STEP_SQ_Y:
            begin
                mul_req.op_a  = {{32{ay_reg[16]}}, ay_reg};
                mul_req.op_b  = {{32{ay_reg[16]}}, ay_reg};
                mul_req.shift = krabe_pkg::SH_NONE;
            end
            krabe_pkg::STEP_SQ_Z:
            begin
                mul_req.op_a  = {{32{az_reg[16]}}, az_reg};
                mul_req.op_b  = {{32{az_reg[16]}}, az_reg};
                mul_req.shift = krabe_pkg::SH_NONE;
            end
            krabe_pkg::STEP_X0:
            begin
                mul_req.op_a  = {20'b0, dt_reg};
                mul_req.op_b  = {{16{ub_c[32]}}, ub_c};
                mul_req.shift = krabe_pkg::SH_DT;
            end
            krabe_pkg::STEP_T11:
            begin
                mul_req.op_a  = {20'b0, dt_reg};
                mul_req.op_b  = {cbb_reg[47], cbb_reg};
                mul_req.shift = krabe_pkg::SH_DT;
            end
            krabe_pkg::STEP_P00_BA:
            begin
                mul_req.op_a  = {20'b0, dt_reg};
                mul_req.op_b  = {cba_reg[47], cba_reg};
                mul_req.shift = krabe_pkg::SH_DT;
            end
            krabe_pkg::STEP_P00_AB:
            begin
                mul_req.op_a  = {20'b0, dt_reg};
                mul_req.op_b  = {cab_reg[47], cab_reg};
                mul_req.shift = krabe_pkg::SH_DT;
            end
            krabe_pkg::STEP_P00_T11:
            begin
                mul_req.op_a  = {20'b0, dt_reg};
                mul_req.op_b  = {t11_reg[47], t11_reg};
                mul_req.shift = krabe_pkg::SH_DT;
            end
            krabe_pkg::STEP_ANGLE:
            begin
                mul_req.op_a = {18'b0, g0_reg};
                mul_req.op_b = {{16{innov_c[32]}}, innov_c};
            end
            krabe_pkg::STEP_BIAS:
            begin
                mul_req.op_a = {g1_reg[47], g1_reg};
                mul_req.op_b = {{16{innov_c[32]}}, innov_c};
            end
            krabe_pkg::STEP_COV_AA:
            begin
                mul_req.op_a = {18'b0, g0_reg};
                mul_req.op_b = {p00_reg[47], p00_reg};
            end
            krabe_pkg::STEP_COV_AB:
            begin
                mul_req.op_a = {18'b0, g0_reg};
                mul_req.op_b = {p01_reg[47], p01_reg};
            end
            krabe_pkg::STEP_COV_BA:
            begin
                mul_req.op_a = {g1_reg[47], g1_reg};
                mul_req.op_b = {p00_reg[47], p00_reg};
            end
            krabe_pkg::STEP_COV_BB:
            begin
                mul_req.op_a = {g1_reg[47], g1_reg};
                mul_req.op_b = {p01_reg[47], p01_reg};
            end
            default:
            begin
                mul_req.op_a = '0;
            end
        endcase
        mul_req.start = (state_reg == krabe_pkg::ST_ISSUE) && !is_div;

        div_req = '0;
        case (step_reg)
            krabe_pkg::STEP_GAIN0:
            begin
                div_req.dividend = {p00_abs, 30'b0};
                div_req.neg      = p00_reg[47];
                div_req.den      = sden_c[47:0];
                div_req.start    = (state_reg == krabe_pkg::ST_ISSUE) && sden_pos;
            end
            krabe_pkg::STEP_GAIN1:
            begin
                div_req.dividend = {p10_abs, 30'b0};
                div_req.neg      = p10_reg[47];
                div_req.den      = sden_reg[47:0];
                div_req.start    = (state_reg == krabe_pkg::ST_ISSUE);
            end
            default:
            begin
                div_req.start = 1'b0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        step_next        = step_reg;
        angle_next       = angle_reg;
        bias_next        = bias_reg;
        caa_next         = caa_reg;
        cab_next         = cab_reg;
        cba_next         = cba_reg;
        cbb_next         = cbb_reg;
        rate_next        = rate_reg;
        y_next           = y_reg;
        dtus_next        = dtus_reg;
        ax_next          = ax_reg;
        ay_next          = ay_reg;
        az_next          = az_reg;
        dt_next          = dt_reg;
        nsq_next         = nsq_reg;
        trusted_next     = trusted_reg;
        x0_next          = x0_reg;
        t11_next         = t11_reg;
        acc_next         = acc_reg;
        p00_next         = p00_reg;
        p01_next         = p01_reg;
        p10_next         = p10_reg;
        p11_next         = p11_reg;
        sden_next        = sden_reg;
        g0_next          = g0_reg;
        g1_next          = g1_reg;
        out_valid_next   = out_valid_reg && out_stall;
        angle_out_next   = angle_out_reg;
        bias_out_next    = bias_out_reg;
        gain_out_next    = gain_out_reg;
        trusted_out_next = trusted_out_reg;
        in_stall         = (state_reg != krabe_pkg::ST_IDLE);

        case (state_reg)
            krabe_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    rate_next    = rate;
                    y_next       = angle_meas;
                    dtus_next    = dt_us;
                    ax_next      = accel_x;
                    ay_next      = accel_y;
                    az_next      = accel_z;
                    g0_next      = '0;
                    trusted_next = 1'b0;
                    if (operation)
                    begin
                        angle_next = {{7{angle_meas[24]}}, angle_meas};
                        bias_next  = '0;
                        state_next = krabe_pkg::ST_OUT;
                    end
                    else
                    begin
                        step_next  = krabe_pkg::STEP_DT;
                        state_next = krabe_pkg::ST_ISSUE;
                    end
                end
            end
            krabe_pkg::ST_ISSUE:
            begin
                if ((step_reg == krabe_pkg::STEP_GAIN0) && !sden_pos)
                begin
                    g0_next   = '0;
                    g1_next   = '0;
                    step_next = krabe_pkg::STEP_ANGLE;
                end
                else
                begin
                    if (step_reg == krabe_pkg::STEP_GAIN0)
                    begin
                        sden_next = sden_c;
                    end
                    state_next = krabe_pkg::ST_WAIT;
                end
            end
            krabe_pkg::ST_WAIT:
            begin
                if (unit_done)
                begin
                    case (step_reg)
                        krabe_pkg::STEP_DT:     dt_next = mul_res[28:0];
                        krabe_pkg::STEP_SQ_X:   nsq_next = mul_res[33:0];
                        krabe_pkg::STEP_SQ_Y:   nsq_next = nsq_c;
                        krabe_pkg::STEP_SQ_Z:
                        begin
                            nsq_next     = nsq_c;
                            trusted_next = (nsq_c >= {2'b0, nsq_low_reg})
                                           && (nsq_c <= {2'b0, nsq_high_reg});
                        end
                        krabe_pkg::STEP_X0:     x0_next = krabe_pkg::sat32(ang66 + m66);
                        krabe_pkg::STEP_T11:    t11_next = mul_res[47:0];
                        krabe_pkg::STEP_P00_BA: acc_next = caa66 - m66;
                        krabe_pkg::STEP_P00_AB: acc_next = acc_reg - m66;
                        krabe_pkg::STEP_P00_T11:
                        begin
                            p00_next = krabe_pkg::sat48(acc_reg + m66 + qa66);
                            p01_next = krabe_pkg::sat48(cab66 - t66);
                            p10_next = krabe_pkg::sat48(cba66 - t66);
                            p11_next = krabe_pkg::sat48(cbb66 + qb66);
                        end
                        krabe_pkg::STEP_GAIN0:
                        begin
                            if (div_quot[47])
                            begin
                                g0_next = '0;
                            end
                            else if (div_quot[46:0] > {16'b0, krabe_pkg::GAIN_ONE})
                            begin
                                g0_next = krabe_pkg::GAIN_ONE;
                            end
                            else
                            begin
                                g0_next = div_quot[30:0];
                            end
                        end
                        krabe_pkg::STEP_GAIN1:  g1_next = div_quot;
                        krabe_pkg::STEP_ANGLE:  angle_next = krabe_pkg::sat32(x066 + m66);
                        krabe_pkg::STEP_BIAS:   bias_next = krabe_pkg::sat32(bias66 + m66);
                        krabe_pkg::STEP_COV_AA: caa_next = krabe_pkg::sat48(p00_66 - m66);
                        krabe_pkg::STEP_COV_AB: cab_next = krabe_pkg::sat48(p01_66 - m66);
                        krabe_pkg::STEP_COV_BA: cba_next = krabe_pkg::sat48(p10_66 - m66);
                        krabe_pkg::STEP_COV_BB: cbb_next = krabe_pkg::sat48(p11_66 - m66);
                        default:                acc_next = acc_reg;
                    endcase
                    if (step_reg == krabe_pkg::STEP_COV_BB)
                    begin
                        state_next = krabe_pkg::ST_OUT;
                    end
                    else
                    begin
                        step_next  = krabe_pkg::step_t'(step_reg + 5'd1);
                        state_next = krabe_pkg::ST_ISSUE;
                    end
                end
            end
            krabe_pkg::ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next   = 1'b1;
                    angle_out_next   = angle_reg;
                    bias_out_next    = bias_reg;
                    gain_out_next    = g0_reg[30:14];
                    trusted_out_next = trusted_reg;
                    state_next       = krabe_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = krabe_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid     = out_valid_reg;
    assign angle_out     = angle_out_reg;
    assign bias_out      = bias_out_reg;
    assign gain_angle    = gain_out_reg;
    assign accel_trusted = trusted_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= krabe_pkg::ST_IDLE;
            step_reg        <= krabe_pkg::STEP_DT;
            out_valid_reg   <= 1'b0;
            angle_reg       <= '0;
            bias_reg        <= '0;
            caa_reg         <= {1'b0, krabe_pkg::Q_ANGLE_RST};
            cab_reg         <= '0;
            cba_reg         <= '0;
            cbb_reg         <= {1'b0, krabe_pkg::Q_BIAS_RST};
            q_angle_reg     <= krabe_pkg::Q_ANGLE_RST;
            q_bias_reg      <= krabe_pkg::Q_BIAS_RST;
            r_trusted_reg   <= krabe_pkg::R_TRUSTED_RST;
            r_untrusted_reg <= krabe_pkg::R_UNTRUSTED_RST;
            nsq_low_reg     <= krabe_pkg::NSQ_LOW_RST;
            nsq_high_reg    <= krabe_pkg::NSQ_HIGH_RST;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            angle_reg     <= angle_next;
            bias_reg      <= bias_next;
            caa_reg       <= caa_next;
            cab_reg       <= cab_next;
            cba_reg       <= cba_next;
            cbb_reg       <= cbb_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    krabe_pkg::CFG_Q_ANGLE:     q_angle_reg     <= cfg_data;
                    krabe_pkg::CFG_Q_BIAS:      q_bias_reg      <= cfg_data;
                    krabe_pkg::CFG_R_TRUSTED:   r_trusted_reg   <= cfg_data;
                    krabe_pkg::CFG_R_UNTRUSTED: r_untrusted_reg <= cfg_data;
                    krabe_pkg::CFG_NSQ_LOW:     nsq_low_reg     <= cfg_data[31:0];
                    krabe_pkg::CFG_NSQ_HIGH:    nsq_high_reg    <= cfg_data[31:0];
                    default:                    nsq_high_reg    <= nsq_high_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rate_reg        <= rate_next;
        y_reg           <= y_next;
        dtus_reg        <= dtus_next;
        ax_reg          <= ax_next;
        ay_reg          <= ay_next;
        az_reg          <= az_next;
        dt_reg          <= dt_next;
        nsq_reg         <= nsq_next;
        trusted_reg     <= trusted_next;
        x0_reg          <= x0_next;
        t11_reg         <= t11_next;
        acc_reg         <= acc_next;
        p00_reg         <= p00_next;
        p01_reg         <= p01_next;
        p10_reg         <= p10_next;
        p11_reg         <= p11_next;
        sden_reg        <= sden_next;
        g0_reg          <= g0_next;
        g1_reg          <= g1_next;
        angle_out_reg   <= angle_out_next;
        bias_out_reg    <= bias_out_next;
        gain_out_reg    <= gain_out_next;
        trusted_out_reg <= trusted_out_next;
    end

`ifndef SYNTHESIS
    a_unit_start: assert property (@(posedge clk) disable iff (!rst_n)
        (mul_req.start || div_req.start) |->
            (state_reg == krabe_pkg::ST_ISSUE) && !(mul_req.start && div_req.start))
        else $error("unit started outside issue or both units started");

    a_mul_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == krabe_pkg::ST_WAIT) && !is_div)
        else $error("multiplier finished while sequencer not waiting on it");

    a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == krabe_pkg::ST_OUT) |-> (g0_reg <= krabe_pkg::GAIN_ONE))
        else $error("angle gain above one");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("sequencer not busy after accepting a word");

    a_gain1_den: assert property (@(posedge clk) disable iff (!rst_n)
        (div_req.start && (step_reg == krabe_pkg::STEP_GAIN1)) |->
            (!sden_reg[48] && (sden_reg != '0)))
        else $error("gain division started with non-positive denominator");
`endif

endmodule

// File: tb/sv/tb_kalman_roll_angle_bias_estimator_top.sv
// self-checking testbench for the roll angle and gyro bias estimator: directed table, random words
module tb_kalman_roll_angle_bias_estimator_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] CFG_UNUSED_LO = 3'd6;
    localparam logic [2:0] CFG_UNUSED_HI = 3'd7;
    localparam logic [46:0] REG_MAX = 47'h7FFF_FFFF_FFFF;

    typedef enum logic {OP_UPDATE = 1'b0, OP_INIT = 1'b1} op_t;

    typedef struct {
        op_t                op;
        logic signed [25:0] rate;
        logic signed [24:0] meas;
        logic [15:0]        dt;
        logic signed [16:0] ax;
        logic signed [16:0] ay;
        logic signed [16:0] az;
    } sample_t;

    typedef struct {
        logic signed [31:0] angle;
        logic signed [31:0] bias;
        logic [16:0]        gain;
        logic               trusted;
    } estimate_t;

    typedef struct {
        sample_t s;
        bit      typed;
        estimate_t e;
    } row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic               operation = 1'b0;
    logic signed [25:0] rate = '0;
    logic signed [24:0] angle_meas = '0;
    logic [15:0]        dt_us = '0;
    logic signed [16:0] accel_x = '0;
    logic signed [16:0] accel_y = '0;
    logic signed [16:0] accel_z = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [31:0] angle_out;
    logic signed [31:0] bias_out;
    logic [16:0]        gain_angle;
    logic               accel_trusted;
    logic               cfg_we = 1'b0;
    logic [2:0]         cfg_index = '0;
    logic [46:0]        cfg_data = '0;

    kalman_roll_angle_bias_estimator_top uut (.*);

    always #1 clk = ~clk;

    longint unsigned regs [6];
    longint est_angle, est_bias, p_aa, p_ab, p_ba, p_bb;
    estimate_t pending_est [$];
    int mismatches = 0;
    int words_sent = 0;
    int words_checked = 0;
    int tx_gap_pct = 0;
    int rx_stall_pct = 0;

    function automatic longint sat_w(longint v, int w);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    function automatic longint round_mul(longint a, longint b, int s);
        logic [127:0] p;
        logic [63:0]  ua;
        logic [63:0]  ub;
        bit           neg;
        neg = (a < 0) != (b < 0);
        ua = a < 0 ? 64'(-a) : 64'(a);
        ub = b < 0 ? 64'(-b) : 64'(b);
        p = {64'd0, ua} * {64'd0, ub};
        p = (p + (128'd1 << (s - 1))) >> s;
        if (p > 128'h4000_0000_0000_0000)
        begin
            p = 128'h4000_0000_0000_0000;
        end
        return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
    endfunction

    function automatic longint gain_div(longint num, longint den);
        logic [127:0] q;
        logic [63:0]  un;
        un = num < 0 ? 64'(-num) : 64'(num);
        q = {34'd0, un, 30'd0} / {64'd0, 64'(den)};
        if (q > 128'(krabe_pkg::GAIN_LIM))
        begin
            q = 128'(krabe_pkg::GAIN_LIM);
        end
        return num < 0 ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    function automatic estimate_t filter_step(sample_t s);
        estimate_t r;
        longint dt, nsq, rv, x0, t11, p00, p01, p10, p11, sden, g0, g1, inn;
        bit tr;
        g0 = 0;
        tr = 0;
        if (s.op == OP_INIT)
        begin
            est_angle = longint'(s.meas);
            est_bias = 0;
        end
        else
        begin
            dt = ((longint'(s.dt) <<< 32) + 500000) / 1000000;
            nsq = longint'(s.ax) * s.ax + longint'(s.ay) * s.ay + longint'(s.az) * s.az;
            tr = nsq >= longint'(regs[4]) && nsq <= longint'(regs[5]);
            rv = longint'(tr ? regs[2] : regs[3]);
            x0 = sat_w(est_angle + round_mul(dt, longint'(s.rate) - est_bias, 32), 32);
            t11 = round_mul(dt, p_bb, 32);
            p00 = sat_w(p_aa - round_mul(dt, p_ba, 32) - round_mul(dt, p_ab, 32)
                        + round_mul(dt, t11, 32) + longint'(regs[0]), 48);
            p01 = sat_w(p_ab - t11, 48);
            p10 = sat_w(p_ba - t11, 48);
            p11 = sat_w(p_bb + longint'(regs[1]), 48);
            sden = p00 + rv;
            g1 = 0;
            if (sden > 0)
            begin
                g0 = gain_div(p00, sden);
                if (g0 < 0)
                begin
                    g0 = 0;
                end
                if (g0 > (longint'(1) <<< 30))
                begin
                    g0 = longint'(1) <<< 30;
                end
                g1 = gain_div(p10, sden);
            end
            inn = longint'(s.meas) - x0;
            est_angle = sat_w(x0 + round_mul(g0, inn, 30), 32);
            est_bias = sat_w(est_bias + round_mul(g1, inn, 30), 32);
            p_aa = sat_w(p00 - round_mul(g0, p00, 30), 48);
            p_ab = sat_w(p01 - round_mul(g0, p01, 30), 48);
            p_ba = sat_w(p10 - round_mul(g1, p00, 30), 48);
            p_bb = sat_w(p11 - round_mul(g1, p01, 30), 48);
        end
        r.angle = est_angle[31:0];
        r.bias = est_bias[31:0];
        r.gain = 17'(g0 >> 14);
        r.trusted = tr;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        mismatches++;
        $display("mismatch %0s at %0t: got %0d expected %0d", what, $realtime, got, want);
    endtask

    always @(posedge clk)
    begin
        out_stall <= rst_n && ($urandom_range(99) < rx_stall_pct);
    end

    always @(posedge clk)
    begin
        estimate_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            words_checked++;
            if (pending_est.size() == 0)
            begin
                report_mismatch("unexpected word", 0, 0);
            end
            else
            begin
                e = pending_est.pop_front();
                if (angle_out !== e.angle)
                    report_mismatch("angle_out", angle_out, e.angle);
                if (bias_out !== e.bias)
                    report_mismatch("bias_out", bias_out, e.bias);
                if (gain_angle !== e.gain)
                    report_mismatch("gain_angle", gain_angle, e.gain);
                if (accel_trusted !== e.trusted)
                    report_mismatch("accel_trusted", accel_trusted, e.trusted);
            end
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [46:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx < 3'd4)
            regs[idx] = val;
        else if (idx < 3'd6)
            regs[idx] = val[31:0];
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_est.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic send(sample_t s, bit typed, estimate_t want);
        estimate_t e;
        in_valid <= 1'b1;
        operation <= s.op;
        rate <= s.rate;
        angle_meas <= s.meas;
        dt_us <= s.dt;
        accel_x <= s.ax;
        accel_y <= s.ay;
        accel_z <= s.az;
        do
            @(posedge clk);
        while (in_stall);
        e = filter_step(s);
        pending_est.push_back(typed ? want : e);
        words_sent++;
        if ($urandom_range(99) < tx_gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    function automatic sample_t mk(op_t op, int r, int m, int d, int x, int y, int z);
        sample_t s;
        s.op = op;
        s.rate = 26'(r);
        s.meas = 25'(m);
        s.dt = 16'(d);
        s.ax = 17'(x);
        s.ay = 17'(y);
        s.az = 17'(z);
        return s;
    endfunction

    function automatic sample_t rand_sample();
        sample_t s;
        int g;
        s.op = $urandom_range(99) < 6 ? OP_INIT : OP_UPDATE;
        s.rate = $urandom_range(99) < 80 ? 26'($signed($urandom_range(0, 2000000)) - 1000000)
                                         : 26'($urandom);
        s.meas = 25'($signed($urandom_range(0, 23592960)) - 11796480);
        s.dt = $urandom_range(99) < 85 ? 16'($urandom_range(500, 20000)) : 16'($urandom);
        if ($urandom_range(99) < 60)
        begin
            g = $urandom_range(6800, 9600);
            s.ax = 17'($signed($urandom_range(0, 3000)) - 1500);
            s.ay = 17'($signed($urandom_range(0, 3000)) - 1500);
            s.az = $urandom_range(1) ? 17'(g) : 17'(-g);
        end
        else
        begin
            s.ax = 17'($urandom);
            s.ay = 17'($urandom);
            s.az = 17'($urandom);
        end
        return s;
    endfunction

    function automatic estimate_t init_est(int m);
        estimate_t e;
        e.angle = m;
        e.bias = 0;
        e.gain = 0;
        e.trusted = 0;
        return e;
    endfunction

    row_t directed [$];
    estimate_t none;

    initial
    begin
        #20000000;
        $display("timeout");
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        regs = '{krabe_pkg::Q_ANGLE_RST, krabe_pkg::Q_BIAS_RST, krabe_pkg::R_TRUSTED_RST,
                 krabe_pkg::R_UNTRUSTED_RST, krabe_pkg::NSQ_LOW_RST, krabe_pkg::NSQ_HIGH_RST};
        est_angle = 0;
        est_bias = 0;
        p_aa = krabe_pkg::Q_ANGLE_RST;
        p_ab = 0;
        p_ba = 0;
        p_bb = krabe_pkg::Q_BIAS_RST;
        none = init_est(0);

        directed.push_back('{mk(OP_UPDATE, 0, 0, 0, 0, 0, 8192), 0, none});
        directed.push_back('{mk(OP_INIT, 0, 11796480, 0, 0, 0, 0), 1, init_est(11796480)});
        directed.push_back('{mk(OP_INIT, -33554432, -11796480, 65535, -65536, -65536, -65536),
                             1, init_est(-11796480)});
        directed.push_back('{mk(OP_UPDATE, 33554431, 11796480, 65535, 65535, 65535, 65535),
                             0, none});
        directed.push_back('{mk(OP_UPDATE, -33554432, -11796480, 65535, -65536, 0, 0), 0, none});
        directed.push_back('{mk(OP_UPDATE, 65536, 0, 5000, 0, 0, 8192), 0, none});
        directed.push_back('{mk(OP_UPDATE, 65536, 0, 5000, 0, 0, 7373), 0, none});
        directed.push_back('{mk(OP_UPDATE, 65536, 0, 5000, 0, 0, 7372), 0, none});
        directed.push_back('{mk(OP_UPDATE, 65536, 0, 5000, 0, 0, 9011), 0, none});
        directed.push_back('{mk(OP_UPDATE, 65536, 0, 5000, 0, 0, 9012), 0, none});
        directed.push_back('{mk(OP_UPDATE, -1, -1, 1, -1, -1, -1), 0, none});
        directed.push_back('{mk(OP_UPDATE, 0, 0, 65535, 0, 0, 0), 0, none});
        directed.push_back('{mk(OP_INIT, 1, 0, 1, 1, 1, 1), 1, init_est(0)});

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        foreach (directed[i])
            send(directed[i].s, directed[i].typed, directed[i].e);
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            tx_gap_pct = (ph % 4 == 1) ? 54 : (ph % 4 == 3) ? 27 : 0;
            rx_stall_pct = (ph % 4 == 2) ? 54 : (ph % 4 == 3) ? 27 : 0;
            case (ph)
                0:
                begin
                    write_reg(krabe_pkg::CFG_Q_ANGLE, '0);
                    write_reg(krabe_pkg::CFG_Q_BIAS, '0);
                    write_reg(krabe_pkg::CFG_R_TRUSTED, 47'd1);
                    write_reg(krabe_pkg::CFG_R_UNTRUSTED, 47'd1);
                end
                1:
                begin
                    write_reg(krabe_pkg::CFG_Q_ANGLE, REG_MAX);
                    write_reg(krabe_pkg::CFG_Q_BIAS, REG_MAX);
                    write_reg(krabe_pkg::CFG_R_TRUSTED, REG_MAX);
                    write_reg(krabe_pkg::CFG_R_UNTRUSTED, REG_MAX);
                    write_reg(krabe_pkg::CFG_NSQ_LOW, '0);
                    write_reg(krabe_pkg::CFG_NSQ_HIGH, 47'hFFFF_FFFF);
                end
                2:
                begin
                    write_reg(krabe_pkg::CFG_Q_ANGLE, 47'(krabe_pkg::Q_ANGLE_RST));
                    write_reg(krabe_pkg::CFG_Q_BIAS, 47'(krabe_pkg::Q_BIAS_RST));
                    write_reg(krabe_pkg::CFG_R_TRUSTED, 47'(krabe_pkg::R_TRUSTED_RST));
                    write_reg(krabe_pkg::CFG_R_UNTRUSTED, 47'(krabe_pkg::R_UNTRUSTED_RST));
                    write_reg(krabe_pkg::CFG_NSQ_LOW, 47'(krabe_pkg::NSQ_HIGH_RST));
                    write_reg(krabe_pkg::CFG_NSQ_HIGH, 47'(krabe_pkg::NSQ_LOW_RST));
                    write_reg(CFG_UNUSED_LO, REG_MAX);
                    write_reg(CFG_UNUSED_HI, '0);
                end
                3:
                begin
                    write_reg(krabe_pkg::CFG_NSQ_LOW, 47'(krabe_pkg::NSQ_LOW_RST));
                    write_reg(krabe_pkg::CFG_NSQ_HIGH, 47'(krabe_pkg::NSQ_HIGH_RST));
                end
                default:
                begin
                    write_reg(krabe_pkg::CFG_Q_ANGLE,
                              47'({$urandom, $urandom}) >> $urandom_range(46));
                    write_reg(krabe_pkg::CFG_Q_BIAS,
                              47'({$urandom, $urandom}) >> $urandom_range(46));
                    write_reg(krabe_pkg::CFG_R_TRUSTED,
                              47'({$urandom, $urandom} >> $urandom_range(46)) | 1);
                    write_reg(krabe_pkg::CFG_R_UNTRUSTED,
                              47'({$urandom, $urandom} >> $urandom_range(46)) | 1);
                    write_reg(krabe_pkg::CFG_NSQ_LOW, 47'($urandom_range(40000000, 70000000)));
                    write_reg(krabe_pkg::CFG_NSQ_HIGH, 47'($urandom_range(60000000, 100000000)));
                end
            endcase
            // start each phase from a known angle so saturation does not dominate
            send(mk(OP_INIT, 0, 0, 0, 0, 0, 0), 1, init_est(0));
            repeat (110)
                send(rand_sample(), 0, none);
            drain();
        end

        $display("sent %0d words, checked %0d output words over 8 register settings",
                 words_sent, words_checked);
        $display("idle patterns: none, sender gaps, receiver stalls, both");
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
